/* hw/rtl/kspi_pkg.sv */
package kspi_pkg;

	// Default sizes of the item store
	localparam int SLOTS_DEF      = 8;
	localparam int VALUE_BITS_DEF = 6;

	// Fixed field widths
	localparam int COMMAND_BITS  = 2;
	localparam int POSITION_BITS = 3;
	localparam int SELECT_BITS   = 4;

	// select_count after reset
	localparam int SELECT_RESET = 5;

	// Command codes; the fourth code is ignored
	typedef enum logic [COMMAND_BITS-1:0] {
		CMD_LOAD    = 2'd0,
		CMD_NEXT    = 2'd1,
		CMD_RESTART = 2'd2
	} cmd_t;

	// Sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EMIT,
		ST_EXH
	} state_t;

	// Per-word control carried alongside a store read
	typedef struct packed {
		logic                     exh;
		logic                     chosen;
		logic [POSITION_BITS-1:0] position;
		logic                     last;
	} token_t;

endpackage

/* hw/rtl/kspi_if.sv */
interface kspi_cmd_if #(
	parameter int VALUE_BITS = kspi_pkg::VALUE_BITS_DEF
);
	logic                              valid;
	logic                              ready;
	logic [kspi_pkg::COMMAND_BITS-1:0] command;
	logic [VALUE_BITS-1:0]             item_value;

	modport source (output valid, command, item_value, input ready);
	modport sink (input valid, command, item_value, output ready);
endinterface

interface kspi_res_if #(
	parameter int VALUE_BITS = kspi_pkg::VALUE_BITS_DEF
);
	logic                               valid;
	logic                               ready;
	logic [VALUE_BITS-1:0]              out_value;
	logic                               chosen;
	logic [kspi_pkg::POSITION_BITS-1:0] position;
	logic                               last_item;
	logic                               exhausted;

	modport source (output valid, out_value, chosen, position, last_item, exhausted,
		input ready);
	modport sink (input valid, out_value, chosen, position, last_item, exhausted,
		output ready);
endinterface

interface kspi_cfg_if;
	logic                             valid;
	logic                             ready;
	logic [kspi_pkg::SELECT_BITS-1:0] data;

	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

/* hw/rtl/kspi_ram.sv */
module kspi_ram #(
	parameter int WIDTH = kspi_pkg::VALUE_BITS_DEF,
	parameter int DEPTH = kspi_pkg::SLOTS_DEF
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Registered read; data holds while no read is issued
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

/* hw/rtl/kspi_gosper.sv */
module kspi_gosper #(
	parameter int MASK_BITS = kspi_pkg::SLOTS_DEF + 1
) (
	input  logic [MASK_BITS-1:0] mask,
	output logic [MASK_BITS-1:0] next_mask
);

	localparam int WIDE   = MASK_BITS + 1;
	localparam int SHIFT_W = $clog2(WIDE + 1);

	logic [WIDE-1:0]    m_w;
	logic [WIDE-1:0]    smallest;
	logic [WIDE-1:0]    ripple;
	logic [WIDE-1:0]    carry_low;
	logic [WIDE-1:0]    ones;
	logic [SHIFT_W-1:0] tz;

	// Isolate lowest set bit and ripple it upward
	always_comb begin
		m_w       = WIDE'(mask);
		smallest  = m_w & (~m_w + WIDE'(1));
		ripple    = m_w + smallest;
		carry_low = ripple & (~ripple + WIDE'(1));
	end

	// Locate the lowest set bit of the original mask
	always_comb begin
		tz = '0;
		for (int i = WIDE - 1; i >= 0; i--) begin
			if (smallest[i]) begin
				tz = SHIFT_W'(i);
			end
		end
	end

	// Refill the low end with the ones that were carried out
	always_comb begin
		ones      = ((carry_low >> tz) >> 1) - WIDE'(1);
		next_mask = MASK_BITS'(ripple | ones);
	end

endmodule

/* hw/rtl/k_subset_partition_iterator.sv */
// Load and restart words produce nothing. A next word that fits shows its first result
// after the emit state, the store read and the result register, then one result per
// cycle while res.ready stays high; the item store read port sets that pace.
// A next word keeps the command side busy until a read is issued for every loaded item.
// An exhausted next gives its single result after the exhausted state, the read stage and the result register.
// Reset clears the sequencer and the loaded count, sets select_count to 5 and the mask
// to its lowest five bits; the item store is not cleared, unread entries stay unknown.
module k_subset_partition_iterator #(
	parameter int SLOTS      = kspi_pkg::SLOTS_DEF,
	parameter int VALUE_BITS = kspi_pkg::VALUE_BITS_DEF
) (
	input logic clk,
	input logic arst_n,
	kspi_cmd_if.sink   cmd,
	kspi_res_if.source res,
	kspi_cfg_if.sink   cfg
);

	localparam int ADDR_W = $clog2(SLOTS);
	localparam int CNT_W  = $clog2(SLOTS + 1);
	localparam int MASK_W = SLOTS + 1;
	localparam int RESET_K = (kspi_pkg::SELECT_RESET > SLOTS) ? SLOTS : kspi_pkg::SELECT_RESET;
	localparam logic [MASK_W-1:0] RESET_MASK = MASK_W'((64'd1 << RESET_K) - 64'd1);

	kspi_pkg::state_t state_q, state_d;
	kspi_pkg::cmd_t   cmd_code;

	logic [kspi_pkg::SELECT_BITS-1:0] select_q;
	logic [MASK_W-1:0]                mask_q;
	logic [MASK_W-1:0]                reload_mask;
	logic [MASK_W-1:0]                advanced_mask;
	logic [CNT_W-1:0]                 count_q;

	logic [SLOTS-1:0] pend_sel_q;
	logic [SLOTS-1:0] pend_rest_q;
	logic [SLOTS-1:0] below_count;
	logic [SLOTS-1:0] cur_pend;
	logic [SLOTS-1:0] cur_onehot;
	logic [ADDR_W-1:0] pick_idx;
	logic             pick_chosen;
	logic             pick_last;
	logic [CNT_W-1:0] n_q;
	logic [CNT_W-1:0] pos_q;

	logic                    valid_s1;
	kspi_pkg::token_t        tok_s1;
	logic [VALUE_BITS-1:0]   rd_data;

	logic                              res_valid_q;
	logic [VALUE_BITS-1:0]             res_value_q;
	logic                              res_chosen_q;
	logic [kspi_pkg::POSITION_BITS-1:0] res_position_q;
	logic                              res_last_q;
	logic                              res_exh_q;

	logic cmd_ready_c;
	logic cmd_fire;
	logic cfg_fire;
	logic load_fire;
	logic next_fire;
	logic restart_fire;
	logic fits;
	logic s1_move;
	logic can_issue;
	logic issue_rd;
	logic issue_exh;

	assign cmd_code = kspi_pkg::cmd_t'(cmd.command);

	// Mask after a reload: lowest select_count bits, saturated into 1..SLOTS
	always_comb begin
		for (int i = 0; i < MASK_W; i++) begin
			reload_mask[i] = (i == 0) || ((i < SLOTS) && (int'(select_q) > i));
		end
	end

	// Check that the mask lies within the loaded items; build the low-count vector
	always_comb begin
		fits = |mask_q;
		for (int i = 0; i < MASK_W; i++) begin
			if (mask_q[i] && (i >= int'(count_q))) begin
				fits = 1'b0;
			end
		end
		for (int i = 0; i < SLOTS; i++) begin
			below_count[i] = i < int'(count_q);
		end
	end

	kspi_gosper #(
		.MASK_BITS (MASK_W)
	) u_gosper (
		.mask      (mask_q),
		.next_mask (advanced_mask)
	);

	// Pick the next stored item: chosen ones first, then the rest
	always_comb begin
		pick_chosen = |pend_sel_q;
		cur_pend    = pick_chosen ? pend_sel_q : pend_rest_q;
		cur_onehot  = cur_pend & (~cur_pend + SLOTS'(1));
		pick_idx    = '0;
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (cur_pend[i]) begin
				pick_idx = ADDR_W'(i);
			end
		end
		pick_last = CNT_W'(pos_q + CNT_W'(1)) == n_q;
	end

	// Handshake and pipeline advance
	always_comb begin
		cmd_ready_c = state_q == kspi_pkg::ST_IDLE;
		cmd_fire    = cmd.valid && cmd_ready_c;
		cfg_fire    = cfg.valid;
		s1_move     = valid_s1 && (!res_valid_q || res.ready);
		can_issue   = !valid_s1 || s1_move;
		issue_rd    = (state_q == kspi_pkg::ST_EMIT) && can_issue;
		issue_exh   = (state_q == kspi_pkg::ST_EXH) && can_issue;
		load_fire   = 1'b0;
		next_fire   = 1'b0;
		restart_fire = 1'b0;
		if (cmd_fire) begin
			case (cmd_code)
				kspi_pkg::CMD_LOAD: begin
					load_fire = count_q < CNT_W'(SLOTS);
				end
				kspi_pkg::CMD_NEXT: begin
					next_fire = fits;
				end
				kspi_pkg::CMD_RESTART: begin
					restart_fire = 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			kspi_pkg::ST_IDLE: begin
				if (cmd_fire && cmd_code == kspi_pkg::CMD_NEXT) begin
					state_d = fits ? kspi_pkg::ST_EMIT : kspi_pkg::ST_EXH;
				end
			end
			kspi_pkg::ST_EMIT: begin
				if (can_issue && pick_last) begin
					state_d = kspi_pkg::ST_IDLE;
				end
			end
			kspi_pkg::ST_EXH: begin
				if (can_issue) begin
					state_d = kspi_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = kspi_pkg::ST_IDLE;
			end
		endcase
	end

	kspi_ram #(
		.WIDTH (VALUE_BITS),
		.DEPTH (SLOTS)
	) u_store (
		.clk     (clk),
		.wr_en   (load_fire),
		.wr_addr (count_q[ADDR_W-1:0]),
		.wr_data (cmd.item_value),
		.rd_en   (issue_rd),
		.rd_addr (pick_idx),
		.rd_data (rd_data)
	);

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= kspi_pkg::ST_IDLE;
			select_q    <= kspi_pkg::SELECT_BITS'(kspi_pkg::SELECT_RESET);
			mask_q      <= RESET_MASK;
			count_q     <= '0;
			valid_s1    <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			// Count loads, drop on restart
			if (load_fire) begin
				count_q <= CNT_W'(count_q + CNT_W'(1));
			end else if (restart_fire) begin
				count_q <= '0;
			end
			// Reload on a write, advance once the order is captured, reload on restart
			if (cfg_fire) begin
				select_q <= cfg.data;
				for (int i = 0; i < MASK_W; i++) begin
					mask_q[i] <= (i == 0) || ((i < SLOTS) && (int'(cfg.data) > i));
				end
			end else if (next_fire) begin
				mask_q <= advanced_mask;
			end else if (restart_fire) begin
				mask_q <= reload_mask;
			end
			// Track the read in flight and the held result word
			if (can_issue) begin
				valid_s1 <= issue_rd || issue_exh;
			end
			if (s1_move) begin
				res_valid_q <= 1'b1;
			end else if (res.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// Sequencing and payload registers
	always_ff @(posedge clk) begin
		if (next_fire) begin
			pend_sel_q  <= mask_q[SLOTS-1:0] & below_count;
			pend_rest_q <= ~mask_q[SLOTS-1:0] & below_count;
			n_q         <= count_q;
			pos_q       <= '0;
		end else if (issue_rd) begin
			if (pick_chosen) begin
				pend_sel_q <= pend_sel_q & ~cur_onehot;
			end else begin
				pend_rest_q <= pend_rest_q & ~cur_onehot;
			end
			pos_q <= CNT_W'(pos_q + CNT_W'(1));
		end
		if (issue_rd) begin
			tok_s1.exh      <= 1'b0;
			tok_s1.chosen   <= pick_chosen;
			tok_s1.position <= kspi_pkg::POSITION_BITS'(pos_q);
			tok_s1.last     <= pick_last;
		end else if (issue_exh) begin
			tok_s1.exh      <= 1'b1;
			tok_s1.chosen   <= 1'b0;
			tok_s1.position <= '0;
			tok_s1.last     <= 1'b1;
		end
		if (s1_move) begin
			res_value_q    <= tok_s1.exh ? '0 : rd_data;
			res_chosen_q   <= tok_s1.chosen;
			res_position_q <= tok_s1.position;
			res_last_q     <= tok_s1.last;
			res_exh_q      <= tok_s1.exh;
		end
	end

	assign cmd.ready     = cmd_ready_c;
	assign cfg.ready     = 1'b1;
	assign res.valid     = res_valid_q;
	assign res.out_value = res_value_q;
	assign res.chosen    = res_chosen_q;
	assign res.position  = res_position_q;
	assign res.last_item = res_last_q;
	assign res.exhausted = res_exh_q;

endmodule
